// ===== rtl/core/seac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and constants of the stereo effect chain.
// Also holds the builder of the overdrive curve, run at elaboration. No dependencies.
package seac_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int TANH_BITS   = 10;
  localparam int TANH_DEPTH  = 1 << TANH_BITS;
  localparam int TANH_AW     = TANH_BITS + 1;
  // Table position of |x|*drive: integer part above IDX_SH, fraction below.
  localparam int IDX_SH      = SAMPLE_BITS + 10 - TANH_BITS;
  localparam int FRAC_BITS   = 24;
  localparam int CFG_DW      = 18;
  localparam int CFG_AW      = 3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_INPUT_GAIN,
    CFG_OUTPUT_GAIN,
    CFG_WET_MIX,
    CFG_DRIVE,
    CFG_ALLPASS_COEF,
    CFG_DELAY_LENGTH,
    CFG_FEEDBACK,
    CFG_EFFECT_CONTROLS
  } cfg_addr_t;

  typedef struct packed {
    logic [15:0]        input_gain;
    logic [15:0]        output_gain;
    logic [15:0]        wet_mix;
    logic [12:0]        drive;
    logic signed [15:0] allpass_coef;
    logic [17:0]        delay_length;
    logic [14:0]        feedback;
    logic [7:0]         effect_controls;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    input_gain:      16'd16384,
    output_gain:     16'd16384,
    wet_mix:         16'd32768,
    drive:           13'd512,
    allpass_coef:    -16'sd28738,
    delay_length:    18'd24000,
    feedback:        15'd9830,
    effect_controls: 8'd7
  };

  // Bit positions in effect_controls.
  localparam int EC_HIGHPASS  = 4;
  localparam int EC_BYP_DRIVE = 5;
  localparam int EC_BYP_CRUSH = 6;
  localparam int EC_BYP_DELAY = 7;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_GAIN, ST_GAIN_W, ST_DRV, ST_DRV_W, ST_ROM, ST_ROM_W,
    ST_AV, ST_AV_W, ST_AAP, ST_AAP_W, ST_CRUSH, ST_FB, ST_FB_W,
    ST_MIX1, ST_MIX2, ST_MIX_W, ST_OG, ST_OG_W
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD,
    OP_GAIN, OP_GAIN_W, OP_DRV, OP_DRV_W, OP_ROM, OP_ROM_W,
    OP_AV, OP_AV_W, OP_AAP, OP_AAP_W, OP_CRUSH, OP_FB, OP_FB_W,
    OP_MIX1, OP_MIX2, OP_MIX_W, OP_OG, OP_OG_W
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mem_re;
    logic   mem_we;
    logic   mem_clr;
    logic   d_from_v;
  } dp_cmd_t;

  typedef logic [SAMPLE_BITS-2:0] tanh_tab_t [TANH_DEPTH+1];

  localparam longint unsigned Q30    = 64'd1 << 30;
  localparam longint unsigned SMAX_U = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // Unsigned quotient by shift and subtract; elaboration only.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-f in Q.30 by a 21-term series; elaboration only.
  function automatic longint unsigned exp_neg_q30(input longint unsigned f);
    longint          sum;
    longint unsigned term;
    sum  = longint'(Q30);
    term = Q30;
    for (int n = 1; n <= 20; n++) begin
      term = udiv((term * f + (Q30 >> 1)) >> 30, 64'(n));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // tanh(8 i / D) for i = 0..D in Q.(SAMPLE_BITS-1).
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t       tab;
    longint unsigned e1;
    longint unsigned z;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned t;
    e1 = exp_neg_q30(Q30);
    for (int i = 0; i <= TANH_DEPTH; i++) begin
      z = (64'(i) << 34) >> TANH_BITS;
      e = exp_neg_q30(z & (Q30 - 64'd1));
      for (int j = 0; j < int'(z >> 30); j++) begin
        e = (e * e1 + (Q30 >> 1)) >> 30;
      end
      if (e > Q30) begin
        e = Q30;
      end
      num = Q30 - e;
      den = Q30 + e;
      t = udiv((num << (SAMPLE_BITS - 1)) + (den >> 1), den);
      if (t > SMAX_U) begin
        t = SMAX_U;
      end
      tab[i] = t[SAMPLE_BITS-2:0];
    end
    return tab;
  endfunction

endpackage

// ===== rtl/core/seac_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the effect chain: steps both lanes through one frame, runs
// the post-reset clearing pass and owns the delay write pointer. Uses seac_pkg.
module seac_ctrl #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  seac_pkg::cfg_t           cfg,
  output seac_pkg::dp_cmd_t        cmd,
  output logic [$clog2(DELAY_DEPTH)-1:0] raddr,
  output logic [$clog2(DELAY_DEPTH)-1:0] waddr
);
  import seac_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] wi_r, wi_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          slot_free;
  logic [AW:0]   len_sat;
  logic [AW:0]   wi_ext;
  logic [AW:0]   rd_sum;
  logic [31:0]   len_wide;

  assign slot_free = !out_valid_r || out_ready;

  // Read position: write pointer minus the delay, clamped to the store depth.
  always_comb begin
    len_wide = 32'(cfg.delay_length);
    len_sat  = (len_wide > 32'(DELAY_DEPTH)) ? (AW+1)'(DELAY_DEPTH) : len_wide[AW:0];
    wi_ext   = {1'b0, wi_r};
    rd_sum   = (wi_ext >= len_sat) ? wi_ext - len_sat
                                   : wi_ext + (AW+1)'(DELAY_DEPTH) - len_sat;
    raddr    = rd_sum[AW-1:0];
    waddr    = (state_r == ST_CLEAR) ? clr_cnt_r : wi_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == AW'(DELAY_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_GAIN;
      ST_GAIN:   state_nxt = ST_GAIN_W;
      ST_GAIN_W: state_nxt = cfg.effect_controls[EC_BYP_DRIVE] ? ST_AV : ST_DRV;
      ST_DRV:    state_nxt = ST_DRV_W;
      ST_DRV_W:  state_nxt = ST_ROM;
      ST_ROM:    state_nxt = ST_ROM_W;
      ST_ROM_W:  state_nxt = ST_AV;
      ST_AV:     state_nxt = ST_AV_W;
      ST_AV_W:   state_nxt = ST_AAP;
      ST_AAP:    state_nxt = ST_AAP_W;
      ST_AAP_W: begin
        if (!cfg.effect_controls[EC_BYP_CRUSH]) begin
          state_nxt = ST_CRUSH;
        end else begin
          state_nxt = cfg.effect_controls[EC_BYP_DELAY] ? ST_MIX1 : ST_FB;
        end
      end
      ST_CRUSH:  state_nxt = cfg.effect_controls[EC_BYP_DELAY] ? ST_MIX1 : ST_FB;
      ST_FB:     state_nxt = ST_FB_W;
      ST_FB_W:   state_nxt = ST_MIX1;
      ST_MIX1:   state_nxt = ST_MIX2;
      ST_MIX2:   state_nxt = ST_MIX_W;
      ST_MIX_W:  state_nxt = ST_OG;
      ST_OG:     state_nxt = ST_OG_W;
      ST_OG_W:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_IDLE, mem_re: 1'b0, mem_we: 1'b0, mem_clr: 1'b0, d_from_v: 1'b0};
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.mem_we  = 1'b1;
        cmd.mem_clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          cmd.mem_re = 1'b1;
        end
      end
      ST_GAIN:   cmd.op = OP_GAIN;
      ST_GAIN_W: cmd.op = OP_GAIN_W;
      ST_DRV:    cmd.op = OP_DRV;
      ST_DRV_W:  cmd.op = OP_DRV_W;
      ST_ROM:    cmd.op = OP_ROM;
      ST_ROM_W:  cmd.op = OP_ROM_W;
      ST_AV:     cmd.op = OP_AV;
      ST_AV_W:   cmd.op = OP_AV_W;
      ST_AAP:    cmd.op = OP_AAP;
      ST_AAP_W:  cmd.op = OP_AAP_W;
      ST_CRUSH:  cmd.op = OP_CRUSH;
      ST_FB: begin
        cmd.op       = OP_FB;
        cmd.d_from_v = (cfg.delay_length == '0);
      end
      ST_FB_W: begin
        cmd.op     = OP_FB_W;
        cmd.mem_we = 1'b1;
      end
      ST_MIX1:   cmd.op = OP_MIX1;
      ST_MIX2:   cmd.op = OP_MIX2;
      ST_MIX_W:  cmd.op = OP_MIX_W;
      ST_OG:     cmd.op = OP_OG;
      ST_OG_W:   if (slot_free) cmd.op = OP_OG_W;
      default:   cmd.op = OP_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    wi_nxt        = wi_r;
    out_valid_nxt = out_valid_r;
    if (state_r == ST_CLEAR) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
    end
    if (state_r == ST_FB_W) begin
      wi_nxt = (wi_r == AW'(DELAY_DEPTH - 1)) ? '0 : wi_r + AW'(1);
    end
    if (state_r == ST_OG_W && slot_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      wi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wi_r        <= wi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/seac_lane.sv =====
`timescale 1ns / 1ps
// One channel of the effect chain: shared multiplier, working registers,
// overdrive ROM and delay store. Driven by seac_ctrl commands; uses seac_pkg.
module seac_lane #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic signed [seac_pkg::SAMPLE_BITS-1:0] x_in,
  input  seac_pkg::cfg_t                         cfg,
  input  seac_pkg::dp_cmd_t                      cmd,
  input  logic [$clog2(DELAY_DEPTH)-1:0]         raddr,
  input  logic [$clog2(DELAY_DEPTH)-1:0]         waddr,
  output logic signed [seac_pkg::SAMPLE_BITS-1:0] y
);
  import seac_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int MA = 34;
  localparam int MB = 25;
  localparam int MP = MA + MB;
  localparam logic signed [63:0] SMAX64 = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN64 = -SMAX64 - 64'sd1;
  localparam logic signed [63:0] I32MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32MIN = -64'sd2147483648;
  localparam tanh_tab_t TANH_ROM = build_tanh();

  function automatic logic signed [SB-1:0] sat_sb(input logic signed [63:0] v);
    if (v > SMAX64) return SB'(SMAX64);
    if (v < SMIN64) return SB'(SMIN64);
    return SB'(v);
  endfunction

  // Round half up, then floor shift.
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  logic signed [SB-1:0]    x_r, v_r, d_r, mem_q_r, y_r;
  logic signed [MP-1:0]    p_r, acc_r, prod;
  logic signed [MA-1:0]    ap_r, mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [31:0]      s_r;
  logic [FRAC_BITS-1:0]    f_r;
  logic                    neg_r;
  logic [SB-2:0]           rom_lo_r, rom_hi_r, rom_d;
  logic [TANH_AW-1:0]      addr_lo, addr_hi;
  logic                    beyond;
  logic signed [SB-1:0]    mem [DELAY_DEPTH];
  logic signed [SB-1:0]    mem_wdata;

  logic signed [63:0] p64, acc64, ap_nxt, s_full, filt, t64, cmag, chalf, cq;
  logic signed [SB:0] vabs;
  logic signed [SB-1:0] d_sel, crush_v;
  logic signed [16:0] m_sat, one_minus;
  logic [4:0] depth;
  int csh;

  assign p64   = 64'(p_r);
  assign acc64 = 64'(acc_r);
  assign vabs  = (v_r < 0) ? -(SB+1)'(v_r) : (SB+1)'(v_r);
  assign rom_d = (rom_hi_r >= rom_lo_r) ? rom_hi_r - rom_lo_r : '0;
  assign d_sel = cmd.d_from_v ? v_r : mem_q_r;
  assign m_sat = (cfg.wet_mix > 16'd32768) ? 17'sd32768 : $signed({1'b0, cfg.wet_mix});
  assign one_minus = 17'sd32768 - m_sat;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_GAIN: begin
        mul_a = MA'(x_r);
        mul_b = MB'($signed({1'b0, cfg.input_gain}));
      end
      OP_DRV: begin
        mul_a = MA'(vabs);
        mul_b = MB'($signed({1'b0, cfg.drive}));
      end
      OP_ROM: begin
        mul_a = MA'($signed({1'b0, rom_d}));
        mul_b = $signed({1'b0, f_r});
      end
      OP_AV: begin
        mul_a = MA'(v_r);
        mul_b = MB'($signed(cfg.allpass_coef));
      end
      OP_AAP: begin
        mul_a = ap_r;
        mul_b = MB'($signed(cfg.allpass_coef));
      end
      OP_FB: begin
        mul_a = MA'(d_sel);
        mul_b = MB'($signed({1'b0, cfg.feedback}));
      end
      OP_MIX1: begin
        mul_a = MA'(x_r);
        mul_b = MB'(one_minus);
      end
      OP_MIX2: begin
        mul_a = MA'(v_r);
        mul_b = MB'(m_sat);
      end
      OP_OG: begin
        mul_a = MA'(v_r);
        mul_b = MB'($signed({1'b0, cfg.output_gain}));
      end
      default: ;
    endcase
  end

  assign prod = MP'(mul_a) * MP'(mul_b);

  // Table position; past the last entry both reads land on it.
  always_comb begin
    beyond  = (p_r[MP-1:IDX_SH+TANH_BITS] != '0);
    addr_lo = beyond ? TANH_AW'(TANH_DEPTH) : {1'b0, p_r[IDX_SH+TANH_BITS-1:IDX_SH]};
    addr_hi = beyond ? TANH_AW'(TANH_DEPTH)
                     : {1'b0, p_r[IDX_SH+TANH_BITS-1:IDX_SH]} + TANH_AW'(1);
  end

  always_comb begin
    ap_nxt = rnd(p64, 15) + 64'(s_r);
    s_full = 64'(v_r) - rnd(p64, 15);
    filt   = cfg.effect_controls[EC_HIGHPASS] ? 64'(v_r) - 64'(ap_r) : 64'(v_r) + 64'(ap_r);
    t64    = 64'($signed({1'b0, rom_lo_r})) + ((p64 + 64'sd8388608) >>> 24);
  end

  // Quantizer: magnitude rounded half away from zero to the step.
  always_comb begin
    depth   = 5'(cfg.effect_controls[3:0]) + 5'd1;
    csh     = SB - 1 - int'(depth);
    cmag    = (v_r < 0) ? -64'(v_r) : 64'(v_r);
    chalf   = '0;
    cq      = '0;
    crush_v = v_r;
    if (csh > 0) begin
      chalf   = 64'sd1 <<< (csh - 1);
      cq      = ((cmag + chalf) >>> csh) <<< csh;
      crush_v = sat_sb((v_r < 0) ? -cq : cq);
    end
  end

  assign mem_wdata = cmd.mem_clr ? '0 : sat_sb(64'(v_r) + rnd(p64, 15));

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[waddr] <= mem_wdata;
    end
    if (cmd.mem_re) begin
      mem_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD:   x_r <= x_in;
      OP_GAIN:   p_r <= prod;
      OP_GAIN_W: v_r <= sat_sb(rnd(p64, 14));
      OP_DRV: begin
        p_r   <= prod;
        neg_r <= (v_r < 0);
      end
      OP_DRV_W: begin
        f_r      <= p_r[FRAC_BITS-1:0];
        rom_lo_r <= TANH_ROM[addr_lo];
        rom_hi_r <= TANH_ROM[addr_hi];
      end
      OP_ROM:    p_r <= prod;
      OP_ROM_W:  v_r <= neg_r ? SB'(-t64) : SB'(t64);
      OP_AV:     p_r <= prod;
      OP_AV_W:   ap_r <= MA'(ap_nxt);
      OP_AAP:    p_r <= prod;
      OP_AAP_W:  v_r <= sat_sb(rnd(filt, 1));
      OP_CRUSH:  v_r <= crush_v;
      OP_FB: begin
        p_r <= prod;
        d_r <= d_sel;
      end
      OP_FB_W:   v_r <= d_r;
      OP_MIX1:   p_r <= prod;
      OP_MIX2: begin
        acc_r <= p_r;
        p_r   <= prod;
      end
      OP_MIX_W:  v_r <= sat_sb(rnd(acc64 + p64, 15));
      OP_OG:     p_r <= prod;
      OP_OG_W:   y_r <= sat_sb(rnd(p64, 14));
      default: ;
    endcase
  end

  // Filter state saturates to 32 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (cmd.op == OP_AAP_W) begin
      if (s_full > I32MAX) begin
        s_r <= 32'(I32MAX);
      end else if (s_full < I32MIN) begin
        s_r <= 32'(I32MIN);
      end else begin
        s_r <= 32'(s_full);
      end
    end
  end

  assign y = y_r;

endmodule

// ===== rtl/core/stereo_audio_effect_chain.sv =====
`timescale 1ns / 1ps
// Top level of the stereo effect chain: configuration registers, sequencer
// and two channel lanes. Depends on seac_pkg, seac_ctrl and seac_lane.
//
// One stereo frame of signed Q1.23 samples is taken per in_ transfer and
// one processed frame leaves per out_ transfer. Both channels run side by
// side in their own lane, each with a single shared multiplier that every
// gain, table interpolation, filter, feedback and mix product goes through
// in turn; that chain of dependent products sets the timing. A new frame
// is taken only once the result of the last one is loaded into the output
// register, and bypassing the overdrive, the quantizer or the delay skips
// its steps of the sequence. One frame is in flight at a time; a finished
// result waits in the output register while the next frame is taken and
// worked on. After reset the delay stores are cleared, one entry per cycle,
// and in_ready stays low meanwhile; configuration writes are taken at any
// time (cfg_ready is always high) but must only change while the block is
// idle. Register indexes follow cfg_addr_t in the package.
module stereo_audio_effect_chain #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [seac_pkg::SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [seac_pkg::SAMPLE_BITS-1:0] in_right_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [seac_pkg::SAMPLE_BITS-1:0] out_left_out,
  output logic signed [seac_pkg::SAMPLE_BITS-1:0] out_right_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [seac_pkg::CFG_AW-1:0]            cfg_index,
  input  logic [seac_pkg::CFG_DW-1:0]            cfg_data
);
  import seac_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  cfg_t          cfg_r, cfg_nxt;
  dp_cmd_t       cmd;
  logic [AW-1:0] raddr, waddr;

  assign cfg_ready = 1'b1;

  // Register file: each write keeps only the register's own width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_addr_t'(cfg_index))
        CFG_INPUT_GAIN:      cfg_nxt.input_gain      = cfg_data[15:0];
        CFG_OUTPUT_GAIN:     cfg_nxt.output_gain     = cfg_data[15:0];
        CFG_WET_MIX:         cfg_nxt.wet_mix         = cfg_data[15:0];
        CFG_DRIVE:           cfg_nxt.drive           = cfg_data[12:0];
        CFG_ALLPASS_COEF:    cfg_nxt.allpass_coef    = $signed(cfg_data[15:0]);
        CFG_DELAY_LENGTH:    cfg_nxt.delay_length    = cfg_data[17:0];
        CFG_FEEDBACK:        cfg_nxt.feedback        = cfg_data[14:0];
        CFG_EFFECT_CONTROLS: cfg_nxt.effect_controls = cfg_data[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer: shared by both lanes, owns the delay pointers.
  seac_ctrl #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .raddr     (raddr),
    .waddr     (waddr)
  );

  seac_lane #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .x_in  (in_left_in),
    .cfg   (cfg_r),
    .cmd   (cmd),
    .raddr (raddr),
    .waddr (waddr),
    .y     (out_left_out)
  );

  seac_lane #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .x_in  (in_right_in),
    .cfg   (cfg_r),
    .cmd   (cmd),
    .raddr (raddr),
    .waddr (waddr),
    .y     (out_right_out)
  );

endmodule

// ===== rtl/core/seac_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the stereo effect chain, bound to the top level.
// Uses seac_pkg for the sample width.
module seac_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [seac_pkg::SAMPLE_BITS-1:0] out_left_out,
  input logic signed [seac_pkg::SAMPLE_BITS-1:0] out_right_out
);
  import seac_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_out) && $stable(out_right_out))
    else $error("stalled result changed or dropped");

  // Clearing pass follows reset: no input transfer right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during store clearing");

  // One frame in flight: busy after each input transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second frame taken while one is in flight");

  // A result never appears the cycle after a frame is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind stereo_audio_effect_chain seac_checker u_seac_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_left_out  (out_left_out),
  .out_right_out (out_right_out)
);
